// File: rtl/hta_pkg.sv
package hta_pkg;

	localparam int SLOTS_DEF = 16;
	localparam int RSVD_DEF  = 3;

	localparam int REQ_W = 3;
	localparam int H_W   = 8;
	localparam int HH_W  = 16;
	localparam int ST_W  = 2;
	localparam int HO_W  = 4;
	localparam int CNT_W = 16;

	// request codes
	localparam logic [REQ_W-1:0] REQ_OPEN   = 3'd0;
	localparam logic [REQ_W-1:0] REQ_CLOSE  = 3'd1;
	localparam logic [REQ_W-1:0] REQ_LOOKUP = 3'd2;
	localparam logic [REQ_W-1:0] REQ_ADD    = 3'd3;
	localparam logic [REQ_W-1:0] REQ_DROP   = 3'd4;

	// status codes
	localparam logic [ST_W-1:0] ST_OK   = 2'd0;
	localparam logic [ST_W-1:0] ST_FULL = 2'd1;
	localparam logic [ST_W-1:0] ST_BADH = 2'd2;

	localparam logic signed [CNT_W-1:0] CNT_MAX = 16'sh7FFF;
	localparam logic signed [CNT_W-1:0] CNT_MIN = 16'sh8000;

	typedef enum logic [2:0] {
		S_IDLE,
		S_EXEC,
		S_WALK,
		S_WOUT,
		S_SUMM
	} state_t;

	typedef struct packed {
		logic cap;       // take request, read handle's entry
		logic exec;      // execute captured request
		logic walk_init; // start release walk
		logic walk_rd;   // read and free slot at walk index
		logic walk_adv;  // step walk index
		logic rel_load;  // emit released-slot result
		logic sum_load;  // emit summary result
	} cmd_t;

	typedef struct packed {
		logic out_free;
		logic drop_walk;
		logic slot_busy;
		logic idx_last;
	} sts_t;

endpackage

// File: rtl/hta_ctrl.sv
module hta_ctrl import hta_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_stall,
	input  sts_t sts,
	output cmd_t cmd
);

	state_t state_q, state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			S_IDLE: begin
				if (req_valid) state_nxt = S_EXEC;
			end
			S_EXEC: begin
				if (sts.out_free) state_nxt = sts.drop_walk ? S_WALK : S_IDLE;
			end
			S_WALK: begin
				if (sts.slot_busy) state_nxt = S_WOUT;
				else if (sts.idx_last) state_nxt = S_SUMM;
			end
			S_WOUT: begin
				if (sts.out_free) state_nxt = sts.idx_last ? S_SUMM : S_WALK;
			end
			S_SUMM: begin
				if (sts.out_free) state_nxt = S_IDLE;
			end
			default: state_nxt = S_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		req_stall = 1'b1;
		case (state_q)
			S_IDLE: begin
				req_stall = 1'b0;
				cmd.cap = req_valid;
			end
			S_EXEC: begin
				cmd.exec = sts.out_free;
				cmd.walk_init = sts.out_free && sts.drop_walk;
			end
			S_WALK: begin
				cmd.walk_rd = sts.slot_busy;
				cmd.walk_adv = !sts.slot_busy;
			end
			S_WOUT: begin
				cmd.rel_load = sts.out_free;
				cmd.walk_adv = sts.out_free;
			end
			S_SUMM: begin
				cmd.sum_load = sts.out_free;
			end
			default: begin
				req_stall = 1'b1;
			end
		endcase
	end

endmodule

// File: rtl/hta_dp.sv
module hta_dp import hta_pkg::*; #(
	parameter int SLOTS          = SLOTS_DEF,
	parameter int RESERVED_SLOTS = RSVD_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  cmd_t                    cmd,
	output sts_t                    sts,
	input  logic [REQ_W-1:0]        req_type,
	input  logic [H_W-1:0]          handle,
	input  logic [HH_W-1:0]         host_handle,
	output logic                    rsp_valid,
	input  logic                    rsp_stall,
	output logic [ST_W-1:0]         status,
	output logic [HO_W-1:0]         handle_out,
	output logic [HH_W-1:0]         host_handle_out,
	output logic signed [CNT_W-1:0] user_count,
	output logic                    released,
	output logic                    last
);

	localparam int IW = $clog2(SLOTS);
	localparam logic [SLOTS-1:0] USED_RST = {{(SLOTS-3){1'b0}}, 3'b111};

	function automatic logic [IW:0] find_free(input logic [SLOTS-1:0] used);
		logic [IW:0] r;
		r = '0;
		for (int i = SLOTS - 1; i >= 0; i--) begin
			if (!used[i]) r = {1'b1, IW'(i)};
		end
		return r;
	endfunction

	logic [SLOTS-1:0]        used_q;
	logic [HH_W-1:0]         mem [SLOTS];
	logic [HH_W-1:0]         mem_q;
	logic                    pre_q;
	logic [1:0]              pre_val_q;
	logic [2:0]              wr_q;
	logic [REQ_W-1:0]        req_q;
	logic [H_W-1:0]          handle_q;
	logic [HH_W-1:0]         hh_q;
	logic signed [CNT_W-1:0] users_q, users_nxt, cnt;
	logic [IW-1:0]           idx_q, rd_addr, free_idx, h_idx;
	logic [IW:0]             free_res;
	logic                    free_found, h_ok, rd_en, wr_en, load;
	logic [HH_W-1:0]         rd_data;
	logic [ST_W-1:0]         st_d;
	logic [HO_W-1:0]         ho_d;
	logic [HH_W-1:0]         hho_d;
	logic                    rel_d, last_d;

	assign free_res   = find_free(used_q);
	assign free_found = free_res[IW];
	assign free_idx   = free_res[IW-1:0];
	assign h_idx      = handle_q[IW-1:0];
	assign h_ok       = (handle_q < H_W'(SLOTS)) && used_q[h_idx];

	// host handle store; entries 0..2 read as their index until first written
	assign rd_addr = cmd.walk_rd ? idx_q : handle[IW-1:0];
	assign rd_en   = cmd.cap || cmd.walk_rd;
	assign wr_en   = cmd.exec && (req_q == REQ_OPEN) && free_found;
	assign rd_data = pre_q ? HH_W'(pre_val_q) : mem_q;

	always_ff @(posedge clk) begin
		if (wr_en) mem[free_idx] <= hh_q;
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			mem_q     <= mem[rd_addr];
			pre_q     <= (rd_addr < IW'(3)) && !wr_q[rd_addr[1:0]];
			pre_val_q <= rd_addr[1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
		end else if (wr_en && (free_idx < IW'(3))) begin
			wr_q[free_idx[1:0]] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.cap) begin
			req_q    <= req_type;
			handle_q <= handle;
			hh_q     <= host_handle;
		end
	end

	always_comb begin
		case (req_q)
			REQ_ADD:  users_nxt = (users_q != CNT_MAX) ? users_q + 16'sd1 : users_q;
			REQ_DROP: users_nxt = (users_q != CNT_MIN) ? users_q - 16'sd1 : users_q;
			default:  users_nxt = users_q;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			users_q <= '0;
			used_q  <= USED_RST;
			idx_q   <= '0;
		end else begin
			if (cmd.exec) begin
				users_q <= users_nxt;
				if ((req_q == REQ_OPEN) && free_found) used_q[free_idx] <= 1'b1;
				if ((req_q == REQ_CLOSE) && h_ok) used_q[h_idx] <= 1'b0;
			end
			if (cmd.walk_rd) used_q[idx_q] <= 1'b0;
			if (cmd.walk_init) idx_q <= IW'(RESERVED_SLOTS);
			else if (cmd.walk_adv) idx_q <= idx_q + IW'(1);
		end
	end

	assign sts.out_free  = !rsp_valid || !rsp_stall;
	assign sts.drop_walk = (req_q == REQ_DROP) && (users_nxt[CNT_W-1] || (users_nxt == '0));
	assign sts.slot_busy = used_q[idx_q];
	assign sts.idx_last  = (idx_q == IW'(SLOTS - 1));

	assign cnt  = cmd.exec ? users_nxt : users_q;
	assign load = (cmd.exec && !sts.drop_walk) || cmd.rel_load || cmd.sum_load;

	always_comb begin
		st_d   = ST_OK;
		ho_d   = '0;
		hho_d  = '0;
		rel_d  = 1'b0;
		last_d = 1'b1;
		if (cmd.rel_load) begin
			ho_d   = HO_W'(idx_q);
			hho_d  = rd_data;
			rel_d  = 1'b1;
			last_d = 1'b0;
		end else if (cmd.exec) begin
			case (req_q)
				REQ_OPEN: begin
					if (free_found) ho_d = HO_W'(free_idx);
					else st_d = ST_FULL;
				end
				REQ_CLOSE, REQ_LOOKUP: begin
					if (h_ok) hho_d = rd_data;
					else st_d = ST_BADH;
				end
				default: st_d = ST_OK;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid <= 1'b0;
		end else if (load) begin
			rsp_valid <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			status          <= st_d;
			handle_out      <= ho_d;
			host_handle_out <= hho_d;
			user_count      <= cnt;
			released        <= rel_d;
			last            <= last_d;
		end
	end

endmodule

// File: rtl/handle_table_allocator.sv
// Handle table allocator: maps small local handles to host handles.
// Request channel (req_valid/req_stall): req_type, handle, host_handle.
//   A word is taken when req_valid is high and req_stall low.
// Response channel (rsp_valid/rsp_stall): status, handle_out,
//   host_handle_out, user_count, released, last. Every request gives one
//   or more response words; the final one has last set.
// Sequence: a request is taken in the idle state and executed in the
//   execute state once the response register is free; the response word
//   is registered at the execute edge. No further request is taken until
//   the controller is idle again.
// A drop that takes the user count to zero or below walks slots
//   RESERVED_SLOTS..SLOTS-1, freeing each occupied slot with a released word
//   (host handle read from the slot store), then emits a summary word.
// Reset: slots 0..2 occupied with host handles 0..2, user count zero,
//   no response pending. No clearing pass is needed.
// When rsp_stall is high the response word holds; req_stall stays low
//   while the controller is idle, so one request may be taken while the
//   previous response still waits.
module handle_table_allocator import hta_pkg::*; #(
	parameter int SLOTS          = SLOTS_DEF,
	parameter int RESERVED_SLOTS = RSVD_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    req_valid,
	output logic                    req_stall,
	input  logic [REQ_W-1:0]        req_type,
	input  logic [H_W-1:0]          handle,
	input  logic [HH_W-1:0]         host_handle,
	output logic                    rsp_valid,
	input  logic                    rsp_stall,
	output logic [ST_W-1:0]         status,
	output logic [HO_W-1:0]         handle_out,
	output logic [HH_W-1:0]         host_handle_out,
	output logic signed [CNT_W-1:0] user_count,
	output logic                    released,
	output logic                    last
);

	// control <-> datapath
	cmd_t cmd;
	sts_t sts;

	hta_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	// bitmap, host handle store, user count and response register
	hta_dp #(
		.SLOTS          (SLOTS),
		.RESERVED_SLOTS (RESERVED_SLOTS)
	) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.sts             (sts),
		.req_type        (req_type),
		.handle          (handle),
		.host_handle     (host_handle),
		.rsp_valid       (rsp_valid),
		.rsp_stall       (rsp_stall),
		.status          (status),
		.handle_out      (handle_out),
		.host_handle_out (host_handle_out),
		.user_count      (user_count),
		.released        (released),
		.last            (last)
	);

endmodule
